@@ rtl/cms_pkg.sv @@
// Shared constants and types for the count-max sketch update block.
// No dependencies; used by cms_bucket and count_max_sketch_update.
`timescale 1ns / 1ps

package cms_pkg;

    localparam int BUCKETS      = 4096;
    localparam int IDX_W        = $clog2(BUCKETS);
    localparam int OUT_IDX_W    = 12;
    localparam int CFG_W        = 13;
    // effective bucket count is at most min(BUCKETS, 2^CFG_W - 1)
    localparam int N_W          = (IDX_W + 1 > CFG_W) ? CFG_W : IDX_W + 1;

    localparam int HASH_W       = 32;
    localparam int PORT_W       = 16;
    localparam int CNT_W        = 32;
    localparam int ADDR_W       = 2 * HASH_W;
    localparam int PPR_W        = 3 * PORT_W;

    localparam logic [HASH_W-1:0] HASH_MUL     = 32'd397;
    localparam logic [CFG_W-1:0]  ACTIVE_RESET = 13'd3000;

    localparam int HASH_STEPS   = 4;
    localparam int MOD_DIG      = 4;
    localparam int MOD_STEPS    = HASH_W / MOD_DIG;
    localparam int STEP_W       = $clog2(MOD_STEPS);

    typedef struct packed {
        logic [HASH_W-1:0] src_ip;
        logic [HASH_W-1:0] dst_ip;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
        logic [PORT_W-1:0] proto;
    } t_key;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PPR_W-1:0]  ppr;
        logic [CNT_W-1:0]  cnt;
    } t_entry;

endpackage

@@ rtl/count_max_sketch_update.sv @@
// Count-max heavy-hitter sketch, one row: per flow beat, hash the key to a bucket
// and read-modify-write the bucket's stored key and counter.
// Depends on cms_pkg and cms_bucket.
//
// One update is in flight at a time: the idle state accepts a beat and starts the
// bucket unit, which runs the multiply-xor hash (one multiply per cycle) and then
// the modulo (4 remainder bits per cycle) and hands the index back; then come the
// bucket memory read, the update and write-back, and the return to idle, where the
// next beat is accepted. The result sits in an output register, so the next input
// beat is taken while it waits; only a result still unread when the next update is
// ready to write back stalls that update. After reset the bucket memory is swept to
// zero, one entry per cycle; no input beat is accepted during the sweep,
// configuration writes are. The bucket count register is used directly, also by an
// update in flight; 0 acts as 1 and values above the memory depth act as the depth.
`timescale 1ns / 1ps

module count_max_sketch_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cms_pkg::HASH_W-1:0]    i_src_ip,
    input  logic [cms_pkg::HASH_W-1:0]    i_dst_ip,
    input  logic [cms_pkg::PORT_W-1:0]    i_src_port,
    input  logic [cms_pkg::PORT_W-1:0]    i_dst_port,
    input  logic [cms_pkg::PORT_W-1:0]    i_proto,
    input  logic [cms_pkg::CNT_W-1:0]     i_weight,
    input  logic                          i_cfg_we,
    input  logic [cms_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cms_pkg::OUT_IDX_W-1:0] o_bucket_index,
    output logic                          o_key_matched,
    output logic                          o_key_replaced,
    output logic [cms_pkg::CNT_W-1:0]     o_counter_after
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CALC, S_READ, S_UPDATE} t_state;

    t_state                           r_state;
    logic [cms_pkg::IDX_W-1:0]        r_clr_addr;
    logic [cms_pkg::CFG_W-1:0]        r_active;
    logic                             r_start;
    cms_pkg::t_key                    r_key;
    logic [cms_pkg::CNT_W-1:0]        r_weight;
    logic [cms_pkg::IDX_W-1:0]        r_idx;
    cms_pkg::t_entry                  r_rd;
    cms_pkg::t_entry                  r_mem [cms_pkg::BUCKETS];

    logic                             r_out_valid;
    logic [cms_pkg::IDX_W-1:0]        r_out_idx;
    logic                             r_out_match;
    logic                             r_out_repl;
    logic [cms_pkg::CNT_W-1:0]        r_out_cnt;

    logic [cms_pkg::N_W-1:0]          n_nbuck;
    logic                             n_match;
    logic                             n_repl;
    logic [cms_pkg::CNT_W-1:0]        n_cnt;
    cms_pkg::t_entry                  n_entry;
    logic                             w_out_free;
    logic                             w_we;
    logic                             w_re;
    logic [cms_pkg::IDX_W-1:0]        w_waddr;
    cms_pkg::t_entry                  w_wdata;
    logic                             w_done;
    logic [cms_pkg::IDX_W-1:0]        w_index;

    always_comb begin
        if (r_active == '0) begin
            n_nbuck = cms_pkg::N_W'(1);
        end else if (32'(r_active) > 32'(cms_pkg::BUCKETS)) begin
            n_nbuck = cms_pkg::N_W'(cms_pkg::BUCKETS);
        end else begin
            n_nbuck = cms_pkg::N_W'(r_active);
        end
    end

    cms_bucket u_bucket (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_key   (r_key),
        .i_nbuck (n_nbuck),
        .o_done  (w_done),
        .o_index (w_index)
    );

    always_comb begin
        n_match = (r_rd.addr == {r_key.src_ip, r_key.dst_ip})
               && (r_rd.ppr == {r_key.src_port, r_key.dst_port, r_key.proto});
        n_repl  = !n_match && (r_weight > r_rd.cnt);
        if (n_match) begin
            n_cnt = r_rd.cnt + r_weight;
        end else if (n_repl) begin
            n_cnt = r_weight - r_rd.cnt;
        end else begin
            n_cnt = r_rd.cnt - r_weight;
        end
        n_entry = r_rd;
        n_entry.cnt = n_cnt;
        if (n_repl) begin
            n_entry.addr = {r_key.src_ip, r_key.dst_ip};
            n_entry.ppr  = {r_key.src_port, r_key.dst_port, r_key.proto};
        end
    end

    assign w_out_free = !r_out_valid || i_ready;
    assign w_re       = (r_state == S_READ);
    assign w_we       = (r_state == S_CLEAR) || ((r_state == S_UPDATE) && w_out_free);
    assign w_waddr    = (r_state == S_CLEAR) ? r_clr_addr : r_idx;
    assign w_wdata    = (r_state == S_CLEAR) ? '0 : n_entry;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_active    <= cms_pkg::ACTIVE_RESET;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            r_start <= (r_state == S_IDLE) && i_valid;
            if ((r_state == S_UPDATE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == cms_pkg::IDX_W'(cms_pkg::BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_key.src_ip   <= i_src_ip;
                        r_key.dst_ip   <= i_dst_ip;
                        r_key.src_port <= i_src_port;
                        r_key.dst_port <= i_dst_port;
                        r_key.proto    <= i_proto;
                        r_weight       <= i_weight;
                        r_state        <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (w_done) begin
                        r_idx   <= w_index;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (w_out_free) begin
                        r_out_idx   <= r_idx;
                        r_out_match <= n_match;
                        r_out_repl  <= n_repl;
                        r_out_cnt   <= n_cnt;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_bucket_index  = cms_pkg::OUT_IDX_W'(r_out_idx);
    assign o_key_matched   = r_out_match;
    assign o_key_replaced  = r_out_repl;
    assign o_counter_after = r_out_cnt;

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (32'(w_index) < 32'(n_nbuck)))
        else $error("bucket index not below active bucket count");

    a_done_only_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_CALC))
        else $error("bucket unit finished outside calc state");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_start && (r_state == S_CALC)))
        else $error("accepted beat did not start bucket unit");

    a_replace_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_replaced) |-> (!o_key_matched && (o_counter_after != '0)))
        else $error("replaced bucket with zero count or match");

endmodule

@@ rtl/cms_bucket.sv @@
// Bucket selection: multiply-xor key hash, then hash modulo the bucket count.
// Hash takes one multiply per cycle; the modulo retires MOD_DIG bits per cycle.
// Depends on cms_pkg.
`timescale 1ns / 1ps

module cms_bucket (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  cms_pkg::t_key             i_key,
    input  logic [cms_pkg::N_W-1:0]   i_nbuck,
    output logic                      o_done,
    output logic [cms_pkg::IDX_W-1:0] o_index
);

    typedef enum logic [1:0] {B_IDLE, B_HASH, B_MOD} t_state;

    t_state                           r_state;
    logic [cms_pkg::STEP_W-1:0]       r_step;
    logic [cms_pkg::HASH_W-1:0]       r_h;
    logic [cms_pkg::N_W-1:0]          r_rem;
    logic                             r_done;

    logic [cms_pkg::HASH_W-1:0]       n_x;
    logic [cms_pkg::HASH_W-1:0]       n_h;
    logic [cms_pkg::N_W-1:0]          n_rem;
    logic [cms_pkg::N_W:0]            n_t;

    always_comb begin
        case (r_step)
            cms_pkg::STEP_W'(0): n_x = i_key.dst_ip;
            cms_pkg::STEP_W'(1): n_x = cms_pkg::HASH_W'(i_key.src_port);
            cms_pkg::STEP_W'(2): n_x = cms_pkg::HASH_W'(i_key.dst_port);
            default:             n_x = cms_pkg::HASH_W'(i_key.proto);
        endcase
        n_h = cms_pkg::HASH_W'(r_h * cms_pkg::HASH_MUL) ^ n_x;
    end

    // restoring remainder, MSB first; remainder stays below i_nbuck
    always_comb begin
        n_rem = r_rem;
        n_t   = '0;
        for (int k = 0; k < cms_pkg::MOD_DIG; k++) begin
            n_t = {n_rem, r_h[cms_pkg::HASH_W-1-k]};
            if (n_t >= {1'b0, i_nbuck}) begin
                n_t = n_t - {1'b0, i_nbuck};
            end
            n_rem = n_t[cms_pkg::N_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == B_MOD)
                   && (r_step == cms_pkg::STEP_W'(cms_pkg::MOD_STEPS - 1));
            case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        r_h     <= i_key.src_ip;
                        r_step  <= '0;
                        r_state <= B_HASH;
                    end
                end
                B_HASH: begin
                    r_h <= n_h;
                    if (r_step == cms_pkg::STEP_W'(cms_pkg::HASH_STEPS - 1)) begin
                        r_step  <= '0;
                        r_rem   <= '0;
                        r_state <= B_MOD;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                B_MOD: begin
                    r_rem <= n_rem;
                    r_h   <= r_h << cms_pkg::MOD_DIG;
                    if (r_step == cms_pkg::STEP_W'(cms_pkg::MOD_STEPS - 1)) begin
                        r_state <= B_IDLE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_index = cms_pkg::IDX_W'(r_rem);

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for count_max_sketch_update: flow beats and bucket-count
// settings against an in-bench sketch predictor, with random stalls on both channels.
// Depends on cms_pkg and the count_max_sketch_update RTL.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        cms_pkg::t_key             key;
        logic [cms_pkg::CNT_W-1:0] weight;
    } t_flow_update;

    typedef struct packed {
        logic [cms_pkg::OUT_IDX_W-1:0] bucket;
        logic                          matched;
        logic                          replaced;
        logic [cms_pkg::CNT_W-1:0]     counter;
    } t_bucket_outcome;

    localparam int IDLE_PCT     = 25;
    localparam int PHASE_BEATS  = 152;
    localparam int POOL_FLOWS   = 24;
    localparam int DRAIN_CYCLES = 20;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          in_valid    = 1'b0;
    logic [cms_pkg::HASH_W-1:0]    in_src_ip   = '0;
    logic [cms_pkg::HASH_W-1:0]    in_dst_ip   = '0;
    logic [cms_pkg::PORT_W-1:0]    in_src_port = '0;
    logic [cms_pkg::PORT_W-1:0]    in_dst_port = '0;
    logic [cms_pkg::PORT_W-1:0]    in_proto    = '0;
    logic [cms_pkg::CNT_W-1:0]     in_weight   = '0;
    logic                          cfg_we      = 1'b0;
    logic [cms_pkg::CFG_W-1:0]     cfg_data    = '0;
    logic                          out_ready   = 1'b0;
    logic                          in_ready;
    logic                          out_valid;
    logic [cms_pkg::OUT_IDX_W-1:0] out_bucket;
    logic                          out_matched;
    logic                          out_replaced;
    logic [cms_pkg::CNT_W-1:0]     out_counter;

    // sketch shadow state
    cms_pkg::t_key             shadow_key   [cms_pkg::BUCKETS];
    logic [cms_pkg::CNT_W-1:0] shadow_count [cms_pkg::BUCKETS];
    logic [cms_pkg::CFG_W-1:0] shadow_active;

    t_bucket_outcome pending_outcomes[$];
    cms_pkg::t_key   flow_pool[$];
    bit              steady = 1'b0;
    int unsigned     err_count = 0;
    int unsigned     outcomes_checked = 0;
    int unsigned     n_matched = 0;
    int unsigned     n_replaced = 0;
    int unsigned     n_reduced = 0;
    int unsigned     n_settings = 0;

    count_max_sketch_update u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_src_ip        (in_src_ip),
        .i_dst_ip        (in_dst_ip),
        .i_src_port      (in_src_port),
        .i_dst_port      (in_dst_port),
        .i_proto         (in_proto),
        .i_weight        (in_weight),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_bucket_index  (out_bucket),
        .o_key_matched   (out_matched),
        .o_key_replaced  (out_replaced),
        .o_counter_after (out_counter)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic t_bucket_outcome predict_update(t_flow_update u);
        t_bucket_outcome            r;
        logic [cms_pkg::HASH_W-1:0] h;
        int unsigned                n;
        int unsigned                slot;
        h = u.key.src_ip;
        h = (h * cms_pkg::HASH_MUL) ^ u.key.dst_ip;
        h = (h * cms_pkg::HASH_MUL) ^ {16'd0, u.key.src_port};
        h = (h * cms_pkg::HASH_MUL) ^ {16'd0, u.key.dst_port};
        h = (h * cms_pkg::HASH_MUL) ^ {16'd0, u.key.proto};
        n = 32'(shadow_active);
        if (n == 0) n = 1;
        if (n > cms_pkg::BUCKETS) n = cms_pkg::BUCKETS;
        slot = h % n;
        r.bucket   = slot[cms_pkg::OUT_IDX_W-1:0];
        r.matched  = 1'b0;
        r.replaced = 1'b0;
        if (shadow_key[slot] == u.key) begin
            r.matched = 1'b1;
            shadow_count[slot] = shadow_count[slot] + u.weight;
            n_matched++;
        end else if (u.weight > shadow_count[slot]) begin
            r.replaced = 1'b1;
            shadow_count[slot] = u.weight - shadow_count[slot];
            shadow_key[slot] = u.key;
            n_replaced++;
        end else begin
            shadow_count[slot] = shadow_count[slot] - u.weight;
            n_reduced++;
        end
        r.counter = shadow_count[slot];
        return r;
    endfunction

    function automatic t_flow_update make_flow(
        logic [cms_pkg::HASH_W-1:0] sip, logic [cms_pkg::HASH_W-1:0] dip,
        logic [cms_pkg::PORT_W-1:0] sp, logic [cms_pkg::PORT_W-1:0] dp,
        logic [cms_pkg::PORT_W-1:0] pr, logic [cms_pkg::CNT_W-1:0] w);
        t_flow_update u;
        u.key.src_ip   = sip;
        u.key.dst_ip   = dip;
        u.key.src_port = sp;
        u.key.dst_port = dp;
        u.key.proto    = pr;
        u.weight       = w;
        return u;
    endfunction

    function automatic cms_pkg::t_key random_key();
        cms_pkg::t_key k;
        k.src_ip   = $urandom;
        k.dst_ip   = $urandom;
        k.src_port = cms_pkg::PORT_W'($urandom_range(65535, 0));
        k.dst_port = cms_pkg::PORT_W'($urandom_range(65535, 0));
        k.proto    = cms_pkg::PORT_W'($urandom_range(65535, 0));
        return k;
    endfunction

    function automatic logic [cms_pkg::CNT_W-1:0] random_weight();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom_range(255, 0);
            5, 6:    return $urandom_range(65535, 0);
            default: return $urandom;
        endcase
    endfunction

    // beat sender: valid stays up across back-to-back beats
    task automatic send_flow(input t_flow_update u);
        while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_src_ip   <= u.key.src_ip;
        in_dst_ip   <= u.key.dst_ip;
        in_src_port <= u.key.src_port;
        in_dst_port <= u.key.dst_port;
        in_proto    <= u.key.proto;
        in_weight   <= u.weight;
        do @(posedge clk); while (!in_ready);
        pending_outcomes.push_back(predict_update(u));
    endtask

    task automatic drain_outcomes();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
    endtask

    task automatic start_phase(input logic [cms_pkg::CFG_W-1:0] value);
        drain_outcomes();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        shadow_active = value;
        n_settings++;
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk) begin
        if (out_ready && out_valid) begin
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result beat: bucket_index %0d", out_bucket);
                err_count++;
            end else begin
                t_bucket_outcome want;
                want = pending_outcomes.pop_front();
                outcomes_checked++;
                if (out_bucket !== want.bucket) begin
                    $error("bucket_index: expected %0d, actual %0d", want.bucket, out_bucket);
                    err_count++;
                end
                if (out_matched !== want.matched) begin
                    $error("key_matched: expected %0d, actual %0d", want.matched, out_matched);
                    err_count++;
                end
                if (out_replaced !== want.replaced) begin
                    $error("key_replaced: expected %0d, actual %0d",
                           want.replaced, out_replaced);
                    err_count++;
                end
                if (out_counter !== want.counter) begin
                    $error("counter_after: expected %0h, actual %0h", want.counter, out_counter);
                    err_count++;
                end
            end
        end
        out_ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    // all-zero key hits the cleared entries; second beat wraps the counter
    task automatic test_zero_key_after_reset();
        send_flow(make_flow('0, '0, '0, '0, '0, 32'd5));
        send_flow(make_flow('0, '0, '0, '0, '0, '1));
    endtask

    task automatic test_field_extremes();
        send_flow(make_flow('1, '1, '1, '1, '1, '0));
        send_flow(make_flow('1, '1, '1, '1, '1, '1));
        send_flow(make_flow('1, '1, '1, '1, '1, 32'd1));
    endtask

    // every flow shares bucket 0: takeover, decay and match
    task automatic test_single_bucket();
        t_flow_update a;
        t_flow_update b;
        a = make_flow(32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 16'd6, '0);
        b = make_flow(32'hC0A8_0101, 32'h0808_0808, 16'd53, 16'd40000, 16'd17, '0);
        start_phase(13'd1);
        a.weight = 32'd10; send_flow(a);
        b.weight = 32'd3;  send_flow(b);
        b.weight = 32'd3;  send_flow(b);
        a.weight = 32'd7;  send_flow(a);
        b.weight = 32'd8;  send_flow(b);
    endtask

    task automatic test_zero_bucket_count();
        t_flow_update a;
        a = make_flow(32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 16'd6, 32'd2);
        start_phase(13'd0);
        send_flow(a);
        a.weight = 32'd1;
        send_flow(a);
        send_flow(make_flow('0, '0, '0, '0, '0, 32'h8000_0000));
    endtask

    task automatic test_oversized_bucket_count();
        t_flow_update u;
        start_phase(13'h1FFF);
        u = {random_key(), random_weight()};
        send_flow(u);
        send_flow({random_key(), random_weight()});
        u.weight = $urandom;
        send_flow(u);
        start_phase(13'd4097);
        send_flow({random_key(), random_weight()});
        send_flow({random_key(), random_weight()});
    endtask

    task automatic test_full_depth();
        start_phase(13'd4096);
        repeat (3) send_flow({random_key(), random_weight()});
    endtask

    // heavy-hitter traffic: mostly a small flow pool, the rest one-off flows
    task automatic test_random_traffic();
        logic [cms_pkg::CFG_W-1:0] settings[12];
        t_flow_update              u;
        settings = '{13'd2, 13'd7, 13'd16, 13'd0, 13'd4096, 13'h1FFF,
                     13'd1, 13'd0, 13'd0, 13'd3000, 13'd64, 13'd4095};
        settings[7] = cms_pkg::CFG_W'($urandom_range(8191, 1));
        settings[8] = cms_pkg::CFG_W'($urandom_range(300, 17));
        for (int p = 0; p < 12; p++) begin
            start_phase(settings[p]);
            steady = (p == 5);
            flow_pool.delete();
            repeat (POOL_FLOWS) flow_pool.push_back(random_key());
            if (p == 3) flow_pool.push_back('0);
            repeat (PHASE_BEATS) begin
                if ($urandom_range(9, 0) < 7)
                    u.key = flow_pool[$urandom_range(flow_pool.size() - 1, 0)];
                else
                    u.key = random_key();
                u.weight = random_weight();
                send_flow(u);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < cms_pkg::BUCKETS; i++) begin
            shadow_key[i]   = '0;
            shadow_count[i] = '0;
        end
        shadow_active = cms_pkg::ACTIVE_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_key_after_reset();
        test_field_extremes();
        test_single_bucket();
        test_zero_bucket_count();
        test_oversized_bucket_count();
        test_full_depth();
        test_random_traffic();

        drain_outcomes();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d flow updates across %0d bucket-count settings",
                 outcomes_checked, n_settings);
        $display("outcomes: %0d key matches, %0d takeovers, %0d counter decays",
                 n_matched, n_replaced, n_reduced);
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ count_max_sketch_update.f @@
rtl/cms_pkg.sv
rtl/cms_bucket.sv
rtl/count_max_sketch_update.sv
tb/sv/tb_top.sv
